/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expects the signals
// clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define SCL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define SCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/scl_pkg.sv */
// ----------------------------------------------------------------------------
// scl_pkg: shared types and constants of the credential lookup unit
// Result codes, record layout, sequencer states and the name normalizer.
// ----------------------------------------------------------------------------
package scl_pkg;

	// Characters of a name or secret that take part in a compare.
	localparam int NAME_CHARS = 8;

	typedef enum logic [2:0] {
		ST_GRANTED = 3'd0,
		ST_UNKNOWN = 3'd1,
		ST_WRONG   = 3'd2,
		ST_STORED  = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	// One credential record as it sits in the table memory.
	typedef struct packed {
		logic [63:0] name;
		logic [63:0] secret;
		logic [15:0] number;
	} rec_t;

	// One normalized input word.
	typedef struct packed {
		logic        query;
		logic        last;
		rec_t        rec;
	} item_t;

	// One result word.
	typedef struct packed {
		status_t     status;
		logic [15:0] number;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SI_RD,
		S_SI_CMP,
		S_SJ_RD,
		S_SJ_CMP,
		S_SW_M,
		S_SW_I,
		S_Q_RD,
		S_Q_CMP,
		S_DONE
	} seq_state_t;

	// Keep the bytes before the first zero byte and within NAME_CHARS.
	function automatic logic [63:0] canon(input logic [63:0] v);
		logic [63:0] r;
		logic        alive;
		logic [7:0]  b;
		r = '0;
		alive = 1'b1;
		for (int k = 0; k < 8; k++) begin
			b = v[63 - 8 * k -: 8];
			if (k >= NAME_CHARS || b == 8'h00) begin
				alive = 1'b0;
			end
			if (alive) begin
				r[63 - 8 * k -: 8] = b;
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/scl_if.sv */
// ----------------------------------------------------------------------------
// scl_if: request and response channels of the credential lookup unit
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface scl_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] name_key;
	logic [63:0] secret;
	logic [15:0] user_number;
	logic        last_record;

	modport source(output valid, command, name_key, secret, user_number, last_record,
		input ready);
	modport sink(input valid, command, name_key, secret, user_number, last_record,
		output ready);
endinterface

interface scl_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] found_number;

	modport source(output valid, status, found_number, input ready);
	modport sink(input valid, status, found_number, output ready);
endinterface

/* hw/rtl/scl_ram.sv */
// ----------------------------------------------------------------------------
// scl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scl_ram #(
	parameter int WIDTH = 144,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/scl_seq.sv */
// ----------------------------------------------------------------------------
// scl_seq: table sequencer
// Stores records, runs the selection sort and the binary search over the
// record memory, at most one memory read or write per step.
// ----------------------------------------------------------------------------
module scl_seq #(
	parameter int ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  scl_pkg::item_t item,
	output logic          idle,
	output logic          res_valid,
	input  logic          res_ready,
	output scl_pkg::rsp_t res
);
	import scl_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = $bits(rec_t);

	seq_state_t    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          sorted_q, sorted_d;

	logic [AW-1:0] i_q, i_d, j_q, j_d, m_q, m_d, mid_q, mid_d;
	logic [CW-1:0] lo_q, lo_d, hix_q, hix_d;
	rec_t          reci_q, reci_d, min_q, min_d;
	logic [63:0]   key_q, key_d, sec_q, sec_d;
	rsp_t          res_q, res_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	rec_t          wdata;
	logic [RW-1:0] rdata_raw;
	rec_t          rdata;
	logic [CW:0]   msum;
	logic [CW-1:0] count_after;

	scl_ram #(
		.WIDTH(RW),
		.DEPTH(ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rdata = rec_t'(rdata_raw);
	assign idle = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res = res_q;

	// Midpoint of the search window [lo, hix).
	assign msum = {1'b0, lo_q} + {1'b0, hix_q} - 1'b1;

	// Next state, memory commands and working registers.
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		sorted_d = sorted_q;
		i_d = i_q;
		j_d = j_q;
		m_d = m_q;
		mid_d = mid_q;
		lo_d = lo_q;
		hix_d = hix_q;
		reci_d = reci_q;
		min_d = min_q;
		key_d = key_q;
		sec_d = sec_q;
		res_d = res_q;
		we = 1'b0;
		waddr = '0;
		wdata = item.rec;
		raddr = '0;
		count_after = count_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					key_d = item.rec.name;
					sec_d = item.rec.secret;
					res_d.number = '0;
					if (!item.query) begin
						// Append the record if there is room.
						if (count_q < CW'(ENTRIES)) begin
							we = 1'b1;
							waddr = count_q[AW-1:0];
							count_after = count_q + 1'b1;
							res_d.status = ST_STORED;
						end else begin
							res_d.status = ST_FULL;
						end
						count_d = count_after;
						sorted_d = 1'b0;
						state_d = S_DONE;
						if (item.last) begin
							i_d = '0;
							if (count_after >= CW'(2)) begin
								state_d = S_SI_RD;
							end else begin
								sorted_d = 1'b1;
							end
						end
					end else begin
						res_d.status = ST_UNKNOWN;
						lo_d = '0;
						hix_d = count_q;
						state_d = sorted_q ? S_Q_RD : S_DONE;
					end
				end
			end
			S_SI_RD: begin
				raddr = i_q;
				state_d = S_SI_CMP;
			end
			S_SI_CMP: begin
				reci_d = rdata;
				min_d = rdata;
				m_d = i_q;
				j_d = i_q + 1'b1;
				state_d = S_SJ_RD;
			end
			S_SJ_RD: begin
				raddr = j_q;
				state_d = S_SJ_CMP;
			end
			S_SJ_CMP: begin
				// Only a strictly smaller key replaces the minimum.
				if (rdata.name < min_q.name) begin
					min_d = rdata;
					m_d = j_q;
				end
				j_d = j_q + 1'b1;
				state_d = (CW'(j_q) + 1'b1 < count_q) ? S_SJ_RD : S_SW_M;
			end
			S_SW_M: begin
				we = 1'b1;
				waddr = m_q;
				wdata = reci_q;
				state_d = S_SW_I;
			end
			S_SW_I: begin
				we = 1'b1;
				waddr = i_q;
				wdata = min_q;
				i_d = i_q + 1'b1;
				if (CW'(i_q) + CW'(2) < count_q) begin
					state_d = S_SI_RD;
				end else begin
					sorted_d = 1'b1;
					state_d = S_DONE;
				end
			end
			S_Q_RD: begin
				if (lo_q < hix_q) begin
					mid_d = msum[AW:1];
					raddr = msum[AW:1];
					state_d = S_Q_CMP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_Q_CMP: begin
				if (rdata.name == key_q) begin
					if (rdata.secret == sec_q) begin
						res_d.status = ST_GRANTED;
						res_d.number = rdata.number;
					end else begin
						res_d.status = ST_WRONG;
					end
					state_d = S_DONE;
				end else begin
					if (rdata.name < key_q) begin
						lo_d = CW'(mid_q) + 1'b1;
					end else begin
						hix_d = CW'(mid_q);
					end
					state_d = S_Q_RD;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			sorted_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			sorted_q <= sorted_d;
		end
	end

	// Working registers of the sort and the search.
	always_ff @(posedge clk) begin
		i_q <= i_d;
		j_q <= j_d;
		m_q <= m_d;
		mid_q <= mid_d;
		lo_q <= lo_d;
		hix_q <= hix_d;
		reci_q <= reci_d;
		min_q <= min_d;
		key_q <= key_d;
		sec_q <= sec_d;
		res_q <= res_d;
	end

endmodule

/* hw/rtl/sorted_credential_lookup_unit.sv */
// A load writes its record and goes to the done state; the result word then passes
// through the output register. A last-marked load first runs a selection sort over
// the stored records when there are at least two. A query on a sorted table reads
// one record per probe of the binary search and stops on a match or an empty window.
// One word at a time: a new word is taken only while the sequencer is idle.
// Reset clears the record count and the sorted flag; the memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_credential_lookup_unit: sorted credential table with binary search
// Loads records, sorts them by name on the last record and answers logins.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_credential_lookup_unit #(
	parameter int ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	scl_req_if.sink   req,
	scl_rsp_if.source rsp
);
	import scl_pkg::*;

	item_t item;
	logic  seq_idle;
	logic  res_valid;
	logic  res_ready;
	rsp_t  res;
	logic  ovalid_q;
	rsp_t  orsp_q;

	// Normalize names and secrets to their string-compare form.
	always_comb begin
		item.query = req.command;
		item.last = req.last_record;
		item.rec.name = canon(req.name_key);
		item.rec.secret = canon(req.secret);
		item.rec.number = req.user_number;
	end

	assign req.ready = seq_idle;

	scl_seq #(
		.ENTRIES(ENTRIES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req.valid),
		.item     (item),
		.idle     (seq_idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register decouples the result word from the sequencer.
	assign res_ready = !ovalid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_ready) begin
			ovalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			orsp_q <= res;
		end
	end

	assign rsp.valid = ovalid_q;
	assign rsp.status = orsp_q.status;
	assign rsp.found_number = orsp_q.number;

	// An accepted word always keeps the sequencer busy for the next cycle.
	`SCL_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
		"sequencer took a second word without finishing the first")
	// Only a granted login carries a user number.
	`SCL_ASSERT(a_number_only_on_grant,
		!rsp.valid || rsp.status == ST_GRANTED || rsp.found_number == 16'd0,
		"found_number is nonzero on a result that is not granted")
	// The sequencer never offers a result while it is idle.
	`SCL_ASSERT(a_no_result_when_idle, !(seq_idle && res_valid),
		"result offered while the sequencer is idle")

endmodule
